// ===== hdl/sdat_pkg.sv =====
`default_nettype none

package sdat_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int TONE_AMP = ((2 ** (SAMPLE_BITS - 1) - 1) + 5) / 10;

    localparam logic [13:0] DELAY_LENGTH_RST    = 14'd7200;
    localparam logic [15:0] TONE_LENGTH_RST     = 16'd7200;
    localparam logic [31:0] TONE_PHASE_STEP_RST = 32'd89478485;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LENGTH    = 2'd0,
        CFG_TONE_LENGTH     = 2'd1,
        CFG_TONE_PHASE_STEP = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          squelch_open;
    } in_req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          muted;
        logic                          tone_active;
    } out_req_t;

    // Entry k of a sine table with 2^tbits entries at amplitude TONE_AMP, built from a
    // quarter wave in Q30 with an odd Taylor polynomial and mirrored by symmetry.
    function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int unsigned k,
                                                          input int unsigned tbits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        quarter = 64'd1 << (tbits - 2);
        q       = 64'(k) >> (tbits - 2);
        r       = 64'(k) & (quarter - 64'd1);
        m       = q[0] ? (quarter - r) : r;
        x       = (m * TWO_PI_Q30 + (64'd1 << (tbits - 1))) >> tbits;
        x2      = (x * x) >> 30;
        t       = Q30_ONE;
        t       = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t       = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t       = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t       = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t       = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s       = (x * t) >> 30;
        v       = (s * 64'(TONE_AMP) + (64'd1 << 29)) >> 30;
        if (q >= 64'd2)
        begin
            v = 64'd0 - v;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/squelch_delay_ack_tone_core.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data   (in_req_t)
// out       output     out_valid / out_ready   out_data  (out_req_t)
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One request per cycle unless the output stalls; each result passes the memory stage, then the output register.
// The delay memory is read and written at the same address in the accepting cycle,
// and the sine table read is registered alongside it.
// Reset is asynchronous; a fill count marks delay entries not yet written, which read
// as zero, so no clearing pass is needed after reset.
// A stalled output holds one result in the output register and one in the memory stage.

module squelch_delay_ack_tone_core
    import sdat_pkg::*;
#(
    parameter int DELAY_DEPTH     = 8192,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_req_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_req_t                    out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W   = $clog2(DELAY_DEPTH);
    localparam int CNT_W    = $clog2(DELAY_DEPTH + 1);
    localparam int ROM_SIZE = 2 ** SINE_TABLE_BITS;

    logic [13:0]                delay_length_reg;
    logic [15:0]                tone_length_reg;
    logic [31:0]                tone_phase_step_reg;

    logic                       mute_reg;
    logic                       mute_next;
    logic [15:0]                trem_reg;
    logic [15:0]                trem_next;
    logic [31:0]                phase_reg;
    logic [31:0]                phase_next;
    logic [ADDR_W-1:0]          idx_reg;
    logic [ADDR_W-1:0]          idx_next;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;

    logic                       s1_valid_reg;
    logic                       s1_tone_reg;
    logic                       s1_muted_reg;
    logic                       s1_hit_reg;
    logic [SAMPLE_BITS-1:0]     mem_q;
    logic [SAMPLE_BITS-1:0]     rom_q;

    logic                       out_valid_reg;
    out_req_t                   out_data_reg;

    logic                       accept;
    logic                       out_free;
    logic                       s1_move;
    logic                       tone_now;
    logic                       hit;
    logic [SAMPLE_BITS-1:0]     wr_sample;
    logic [15:0]                trem_cur;
    logic [31:0]                cfg_len32;
    logic [CNT_W-1:0]           len_eff;
    logic [CNT_W-1:0]           idx_ext;
    logic [CNT_W-1:0]           idx_inc;

    logic [SAMPLE_BITS-1:0]     delay_mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0]     sine_rom  [ROM_SIZE];

    for (genvar k = 0; k < ROM_SIZE; k++)
    begin : g_rom
        localparam logic [SAMPLE_BITS-1:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
        assign sine_rom[k] = ENTRY;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        mute_next = mute_reg;
        trem_cur  = trem_reg;
        wr_sample = in_data.sample_in;
        if (!in_data.squelch_open)
        begin
            if (!mute_reg)
            begin
                trem_cur = tone_length_reg;
            end
            mute_next = 1'b1;
            wr_sample = '0;
        end
        else
        begin
            mute_next = 1'b0;
        end

        tone_now   = trem_cur != 16'd0;
        trem_next  = tone_now ? trem_cur - 16'd1 : trem_cur;
        phase_next = tone_now ? phase_reg + tone_phase_step_reg : phase_reg;

        cfg_len32 = 32'(delay_length_reg);
        if (cfg_len32 == 32'd0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (cfg_len32 > 32'(DELAY_DEPTH))
        begin
            len_eff = CNT_W'(DELAY_DEPTH);
        end
        else
        begin
            len_eff = CNT_W'(cfg_len32);
        end

        idx_ext   = CNT_W'(idx_reg);
        idx_inc   = idx_ext + CNT_W'(1);
        idx_next  = (idx_inc >= len_eff) ? '0 : idx_inc[ADDR_W-1:0];
        hit       = idx_ext < fill_reg;
        fill_next = (idx_ext == fill_reg) ? idx_inc : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg    <= DELAY_LENGTH_RST;
            tone_length_reg     <= TONE_LENGTH_RST;
            tone_phase_step_reg <= TONE_PHASE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH:    delay_length_reg    <= cfg_data[13:0];
                CFG_TONE_LENGTH:     tone_length_reg     <= cfg_data[15:0];
                CFG_TONE_PHASE_STEP: tone_phase_step_reg <= cfg_data[31:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_reg     <= 1'b1;
            trem_reg     <= '0;
            phase_reg    <= '0;
            idx_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_tone_reg  <= 1'b0;
            s1_muted_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mute_reg     <= mute_next;
                trem_reg     <= trem_next;
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                fill_reg     <= fill_next;
                s1_valid_reg <= 1'b1;
                s1_tone_reg  <= tone_now;
                s1_muted_reg <= mute_next;
                s1_hit_reg   <= hit;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q              <= delay_mem[idx_reg];
            delay_mem[idx_reg] <= wr_sample;
            rom_q              <= sine_rom[phase_reg[31 -: SINE_TABLE_BITS]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg.sample_out  <= s1_tone_reg ? rom_q : (s1_hit_reg ? mem_q : '0);
            out_data_reg.muted       <= s1_muted_reg;
            out_data_reg.tone_active <= s1_tone_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sdat_checker.sv =====
`default_nettype none

module sdat_checker
    import sdat_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire out_req_t               out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result changed while stalled.");

    // A tone sample never exceeds the tone amplitude.
    a_tone_amp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tone_active |->
            ($signed(out_data.sample_out) <= $signed(TONE_AMP)) &&
            ($signed(out_data.sample_out) >= -$signed(TONE_AMP)))
        else $error("Tone sample outside its amplitude.");

    // A result that appears on an idle output has passed the memory stage and the output register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("Result appeared without a matching request.");

    // With both internal stages full and the output stalled, no request is taken.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(in_valid && in_ready) &&
        $past(out_valid && !out_ready) |-> !in_ready)
        else $error("Request taken while the pipeline is full.");

endmodule

bind squelch_delay_ack_tone_core sdat_checker u_sdat_checker (.*);

`default_nettype wire
